// ===== sv/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the track label stabilizer.
// ----------------------------------------------------------------------------
package tls_pkg;

   localparam int TRACK_SLOTS_DEF = 256;

   // Widest slot value the table can reach (4096 entries) plus one bit
   localparam int SLOT_EXT_W = 13;

   localparam int SLOT_W  = 8;
   localparam int LABEL_W = 3;
   localparam int CNT_W   = 8;
   localparam int CFG_W   = 8;
   localparam int CSR_INDEX_W = 1;

   // Entry layout: {fixed, label, count, run}
   localparam int ENTRY_W = 1 + LABEL_W + CNT_W + CNT_W;

   localparam logic [LABEL_W-1:0] NOTSURE = '0;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIX_FRAMES   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ABORT_FRAMES = 1'b1;

   localparam logic [CFG_W-1:0] FIX_FRAMES_RST   = 8'd5;
   localparam logic [CFG_W-1:0] ABORT_FRAMES_RST = 8'd20;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_FIXED   = 2'd1,
      ST_NEW     = 2'd2,
      ST_ABORT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_UPDATE
   } state_type;

   typedef struct packed {
      logic clear;        // write zero at the sweep address
      logic accept;       // capture the incoming transaction
      logic use_req_addr; // table read address from the request port
      logic commit;       // write back the entry and load the response
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== sv/tls_ram.sv =====
// ----------------------------------------------------------------------------
// tls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/tls_datapath.sv =====
// ----------------------------------------------------------------------------
// tls_datapath
// Track table, configuration registers, entry update and response register.
// ----------------------------------------------------------------------------
module tls_datapath #(
   parameter int TRACK_SLOTS = tls_pkg::TRACK_SLOTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tls_pkg::ctrl_cmd_type               cmd,
   output tls_pkg::dp_status_type              stat,
   input  logic                                csr_we,
   input  logic [tls_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tls_pkg::CFG_W-1:0]           csr_wdata,
   input  logic [tls_pkg::SLOT_W-1:0]          req_track_slot,
   input  logic [tls_pkg::LABEL_W-1:0]         req_frame_label,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tls_pkg::SLOT_W-1:0]          rsp_out_slot,
   output logic [1:0]                          rsp_status,
   output logic [tls_pkg::LABEL_W-1:0]         rsp_out_label
);

   localparam int AW = $clog2(TRACK_SLOTS);
   localparam int EXT_W = tls_pkg::SLOT_EXT_W;
   localparam int LW = tls_pkg::LABEL_W;
   localparam int CW = tls_pkg::CNT_W;

   logic [tls_pkg::CFG_W-1:0] fix_frames_ff, abort_frames_ff;
   logic [tls_pkg::SLOT_W-1:0] slot_ff;
   logic [LW-1:0] label_ff;
   logic [AW-1:0] clr_ff;

   logic rsp_valid_ff;
   logic [tls_pkg::SLOT_W-1:0] rsp_slot_ff;
   tls_pkg::status_type rsp_status_ff;
   logic [LW-1:0] rsp_label_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fix_frames_ff   <= tls_pkg::FIX_FRAMES_RST;
         abort_frames_ff <= tls_pkg::ABORT_FRAMES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tls_pkg::CSR_FIX_FRAMES:   fix_frames_ff   <= csr_wdata;
            tls_pkg::CSR_ABORT_FRAMES: abort_frames_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign stat.clear_done = (clr_ff == AW'(TRACK_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff  <= req_track_slot;
         label_ff <= req_frame_label;
      end
   end

   // Table access
   logic [EXT_W-1:0] req_ext, held_ext;
   logic in_range;
   logic [AW-1:0] raddr, waddr;
   logic we;
   logic [tls_pkg::ENTRY_W-1:0] rdata, wdata, entry_new;

   assign req_ext  = EXT_W'(req_track_slot);
   assign held_ext = EXT_W'(slot_ff);
   assign in_range = held_ext < EXT_W'(TRACK_SLOTS);
   assign raddr    = cmd.use_req_addr ? req_ext[AW-1:0] : held_ext[AW-1:0];

   tls_ram #(
      .WIDTH (tls_pkg::ENTRY_W),
      .DEPTH (TRACK_SLOTS)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Entry update
   logic          e_fixed;
   logic [LW-1:0] e_label;
   logic [CW-1:0] e_count, e_run;
   logic [CW-1:0] need, n_count, n_run;
   logic [LW-1:0] n_label;
   logic          n_fixed;
   tls_pkg::status_type st;
   logic [LW-1:0] olab;

   assign {e_fixed, e_label, e_count, e_run} = rdata;

   always_comb begin
      need    = (fix_frames_ff == '0) ? CW'(1) : fix_frames_ff;
      n_count = (e_count == '1) ? e_count : e_count + 1'b1;
      if (e_run != '0 && e_label == label_ff) begin
         n_run   = (e_run == '1) ? e_run : e_run + 1'b1;
         n_label = e_label;
      end else begin
         n_run   = CW'(1);
         n_label = label_ff;
      end
      n_fixed = 1'b0;
      st      = tls_pkg::ST_PENDING;
      olab    = '0;
      if (!in_range) begin
         st = tls_pkg::ST_PENDING;
      end else if (e_fixed) begin
         st   = tls_pkg::ST_FIXED;
         olab = e_label;
      end else if (n_count > abort_frames_ff) begin
         // abort takes priority over a run that is long enough
         n_fixed = 1'b1;
         n_label = tls_pkg::NOTSURE;
         st      = tls_pkg::ST_ABORT;
      end else if (n_label != tls_pkg::NOTSURE && n_run >= need) begin
         n_fixed = 1'b1;
         st      = tls_pkg::ST_NEW;
         olab    = n_label;
      end
   end

   assign entry_new = {n_fixed, n_label, n_count, n_run};
   assign we    = cmd.clear | (cmd.commit & in_range & ~e_fixed);
   assign waddr = cmd.clear ? clr_ff : held_ext[AW-1:0];
   assign wdata = cmd.clear ? '0 : entry_new;

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff   <= slot_ff;
         rsp_status_ff <= st;
         rsp_label_ff  <= olab;
      end
   end

   assign stat.rsp_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_slot  = rsp_slot_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_label = rsp_label_ff;

endmodule

// ===== sv/tls_ctrl.sv =====
// ----------------------------------------------------------------------------
// tls_ctrl
// Sequencer: table clearing sweep, request accept, read-modify-write commit.
// ----------------------------------------------------------------------------
module tls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tls_pkg::dp_status_type stat,
   output tls_pkg::ctrl_cmd_type  cmd
);

   tls_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tls_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         tls_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = tls_pkg::S_IDLE;
            end
         end
         tls_pkg::S_IDLE: begin
            req_ready        = 1'b1;
            cmd.use_req_addr = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = tls_pkg::S_UPDATE;
            end
         end
         tls_pkg::S_UPDATE: begin
            // entry read data is valid here; hold until the response slot frees
            if (stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = tls_pkg::S_IDLE;
            end
         end
         default: state_in = tls_pkg::S_CLEAR;
      endcase
   end

endmodule

// ===== sv/track_label_stabilizer_core.sv =====
// ----------------------------------------------------------------------------
// track_label_stabilizer_core
// Per-track class label stabilizer with a table of fix/abort state.
// ----------------------------------------------------------------------------
// Each request names a track slot and the frame's class label (0 = not sure)
// and yields exactly one response with the slot, a status (pending, already
// fixed, newly fixed, aborted) and the fixed label. The accept cycle reads
// the track entry from the table RAM; the update state then waits until the
// response register is free, writes the updated entry back and loads the
// response register, so the single table read-then-write sets the rate. A new
// request is taken while the previous response still waits on rsp_ready.
// After reset the table is cleared by a sweep over all TRACK_SLOTS entries,
// during which req_ready is low; configuration writes are taken at any time.
module track_label_stabilizer_core #(
   parameter int TRACK_SLOTS = tls_pkg::TRACK_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tls_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tls_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tls_pkg::SLOT_W-1:0]      req_track_slot,
   input  logic [tls_pkg::LABEL_W-1:0]     req_frame_label,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tls_pkg::SLOT_W-1:0]      rsp_out_slot,
   output logic [1:0]                      rsp_status,
   output logic [tls_pkg::LABEL_W-1:0]     rsp_out_label
);

   tls_pkg::ctrl_cmd_type  cmd;
   tls_pkg::dp_status_type stat;

   tls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tls_datapath #(
      .TRACK_SLOTS (TRACK_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_track_slot  (req_track_slot),
      .req_frame_label (req_frame_label),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_slot    (rsp_out_slot),
      .rsp_status      (rsp_status),
      .rsp_out_label   (rsp_out_label)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for track_label_stabilizer_core.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the per-track table and both limits. It
// predicts one response per accepted request and compares the responses in
// order. A short directed run covers fixing, aborting and the zero and
// saturating limit cases. Randomized phases follow, each under its own limits
// and one of three idling profiles; one phase holds the response side off long
// enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;

   localparam int SLOTS       = tls_pkg::TRACK_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 300;
   localparam int POOL_TRIES  = 64;

   typedef struct packed {
      logic [tls_pkg::SLOT_W-1:0]  slot;
      tls_pkg::status_type         status;
      logic [tls_pkg::LABEL_W-1:0] label;
   } verdict_type;

   class label_scoreboard;
      logic [tls_pkg::CFG_W-1:0]   fix_limit;
      logic [tls_pkg::CFG_W-1:0]   abort_limit;
      bit                          trk_fixed [SLOTS];
      logic [tls_pkg::LABEL_W-1:0] trk_label [SLOTS];
      logic [tls_pkg::CNT_W-1:0]   trk_count [SLOTS];
      logic [tls_pkg::CNT_W-1:0]   trk_run   [SLOTS];
      verdict_type                 verdicts[$];
      int errors;
      int checked;
      int n_new;
      int n_abort;
      int n_held;

      function new();
         fix_limit   = tls_pkg::FIX_FRAMES_RST;
         abort_limit = tls_pkg::ABORT_FRAMES_RST;
         for (int i = 0; i < SLOTS; i++) begin
            trk_fixed[i] = 1'b0;
            trk_label[i] = '0;
            trk_count[i] = '0;
            trk_run[i]   = '0;
         end
      endfunction

      function void set_register(logic [tls_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [tls_pkg::CFG_W-1:0] value);
         if (idx == tls_pkg::CSR_FIX_FRAMES) begin
            fix_limit = value;
         end else if (idx == tls_pkg::CSR_ABORT_FRAMES) begin
            abort_limit = value;
         end
      endfunction

      function bit is_fixed(int slot);
         return (slot < SLOTS) ? trk_fixed[slot] : 1'b1;
      endfunction

      function logic [tls_pkg::CNT_W-1:0] bump(logic [tls_pkg::CNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // Track update for one accepted request
      function void note_request(logic [tls_pkg::SLOT_W-1:0] slot,
                                 logic [tls_pkg::LABEL_W-1:0] label);
         verdict_type               v;
         logic [tls_pkg::CFG_W-1:0] need;
         v.slot   = slot;
         v.status = tls_pkg::ST_PENDING;
         v.label  = tls_pkg::NOTSURE;
         if (slot < SLOTS) begin
            if (trk_fixed[slot]) begin
               v.status = tls_pkg::ST_FIXED;
               v.label  = trk_label[slot];
            end else begin
               need = (fix_limit == '0) ? tls_pkg::CFG_W'(1) : fix_limit;
               trk_count[slot] = bump(trk_count[slot]);
               if (trk_run[slot] != '0 && trk_label[slot] == label) begin
                  trk_run[slot] = bump(trk_run[slot]);
               end else begin
                  trk_label[slot] = label;
                  trk_run[slot]   = tls_pkg::CNT_W'(1);
               end
               // abort check wins over a long enough run
               if (trk_count[slot] > abort_limit) begin
                  trk_fixed[slot] = 1'b1;
                  trk_label[slot] = tls_pkg::NOTSURE;
                  v.status        = tls_pkg::ST_ABORT;
               end else if (trk_label[slot] != tls_pkg::NOTSURE &&
                            trk_run[slot] >= need) begin
                  trk_fixed[slot] = 1'b1;
                  v.status        = tls_pkg::ST_NEW;
                  v.label         = trk_label[slot];
               end
            end
         end
         verdicts.insert(verdicts.size(), v);
      endfunction

      function void check_response(logic [tls_pkg::SLOT_W-1:0] slot, logic [1:0] status,
                                   logic [tls_pkg::LABEL_W-1:0] label);
         verdict_type v;
         if (verdicts.size() == 0) begin
            $display("%0t: unexpected response slot %0d status %0d label %0d",
                     $time, slot, status, label);
            errors++;
            return;
         end
         v = verdicts.pop_front();
         checked++;
         if (slot !== v.slot) begin
            $display("%0t: out_slot expected %0d actual %0d", $time, v.slot, slot);
            errors++;
         end
         if (status !== v.status) begin
            $display("%0t: status (slot %0d) expected %0d actual %0d",
                     $time, v.slot, v.status, status);
            errors++;
         end
         if (label !== v.label) begin
            $display("%0t: out_label (slot %0d) expected %0d actual %0d",
                     $time, v.slot, v.label, label);
            errors++;
         end
         case (v.status)
            tls_pkg::ST_NEW:   n_new++;
            tls_pkg::ST_ABORT: n_abort++;
            tls_pkg::ST_FIXED: n_held++;
            default: ;
         endcase
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [tls_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [tls_pkg::CFG_W-1:0]       csr_wdata;
   logic                            req_valid;
   logic                            req_ready;
   logic [tls_pkg::SLOT_W-1:0]      req_track_slot;
   logic [tls_pkg::LABEL_W-1:0]     req_frame_label;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [tls_pkg::SLOT_W-1:0]      rsp_out_slot;
   logic [1:0]                      rsp_status;
   logic [tls_pkg::LABEL_W-1:0]     rsp_out_label;

   label_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_trigger;
   int cycle_count;
   int settings_used;
   int pool_slot  [16];
   int pool_label [16];

   track_label_stabilizer_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_track_slot  (req_track_slot),
      .req_frame_label (req_frame_label),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_slot    (rsp_out_slot),
      .rsp_status      (rsp_status),
      .rsp_out_label   (rsp_out_label)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("track_label_stabilizer_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_out_slot, rsp_status, rsp_out_label);
      end
   end

   // Response side; a bump of hold_trigger starts one long hold-off
   initial begin
      int hold_left;
      int seen_trigger;
      hold_left    = 0;
      seen_trigger = 0;
      rsp_ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_trigger != seen_trigger) begin
            seen_trigger = hold_trigger;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Called at a falling edge while the block is idle; leaves csr_we high
   task automatic write_register(logic [tls_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [tls_pkg::CFG_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic set_limits(logic [tls_pkg::CFG_W-1:0] fix,
                             logic [tls_pkg::CFG_W-1:0] abort_lim);
      write_register(tls_pkg::CSR_FIX_FRAMES, fix);
      write_register(tls_pkg::CSR_ABORT_FRAMES, abort_lim);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Called at a falling edge; returns at a falling edge
   task automatic send_request(logic [tls_pkg::SLOT_W-1:0] slot,
                               logic [tls_pkg::LABEL_W-1:0] label);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_track_slot  <= slot;
      req_frame_label <= label;
      do @(posedge clock); while (!req_ready);
      sb.note_request(slot, label);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.verdicts.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(int fix, int abort_lim, int pool_n, int items);
      int k;
      int tries;
      logic [tls_pkg::SLOT_W-1:0]  slot;
      logic [tls_pkg::LABEL_W-1:0] label;
      set_limits(tls_pkg::CFG_W'(fix), tls_pkg::CFG_W'(abort_lim));
      for (int i = 0; i < pool_n; i++) begin
         tries = 0;
         do begin
            pool_slot[i] = $urandom_range(SLOTS - 1);
            tries++;
         end while (sb.is_fixed(pool_slot[i]) && tries < POOL_TRIES);
         pool_label[i] = (pool_n == 1) ? 0 : $urandom_range(7);
      end
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < 85) begin
            k = $urandom_range(pool_n - 1);
            if (sb.is_fixed(pool_slot[k]) && $urandom_range(3) != 0) begin
               pool_slot[k]  = $urandom_range(SLOTS - 1);
               pool_label[k] = $urandom_range(7);
            end
            slot  = tls_pkg::SLOT_W'(pool_slot[k]);
            label = ($urandom_range(99) < 80) ? tls_pkg::LABEL_W'(pool_label[k]) :
                                                tls_pkg::LABEL_W'($urandom_range(7));
         end else begin
            slot  = tls_pkg::SLOT_W'($urandom_range(SLOTS - 1));
            label = tls_pkg::LABEL_W'($urandom_range(7));
         end
         send_request(slot, label);
      end
      drain();
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_track_slot  = '0;
      req_frame_label = '0;
      send_idle_pct   = 6;
      recv_idle_pct   = 76;
      hold_trigger    = 0;
      cycle_count     = 0;
      settings_used   = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset limits: fix after five equal labels, back-to-back on one slot
      repeat (5) send_request(8'd0, 3'd3);
      send_request(8'd0, 3'd7);
      send_request(8'd255, 3'd7);
      send_request(8'd255, 3'd7);
      send_request(8'd255, 3'd0);
      send_request(8'd255, 3'd7);
      send_request(8'd128, 3'd0);
      send_request(8'd128, 3'd0);
      drain();
      // Zero limits: the abort check wins on the very first frame
      set_limits(8'd0, 8'd0);
      send_request(8'd10, 3'd5);
      send_request(8'd10, 3'd2);
      drain();
      // Zero fix limit acts as one; abort limit at the top never aborts
      set_limits(8'd0, 8'd255);
      send_request(8'd20, 3'd6);
      send_request(8'd21, 3'd0);
      send_request(8'd20, 3'd1);
      drain();

      run_phase(3, 12, 8, 250);
      run_phase(1, 254, 8, 200);
      send_idle_pct = 76;
      recv_idle_pct = 6;
      run_phase(254, 1, 6, 150);
      // One slot fed mostly not-sure labels: counters saturate
      run_phase(255, 255, 1, 400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_trigger++;
      run_phase(2, 6, 12, 200);
      run_phase(7, 30, 10, 100);

      repeat (8) @(posedge clock);
      $display("run: %0d responses checked under %0d limit settings",
               sb.checked, settings_used + 1);
      $display("run: %0d tracks newly fixed, %0d aborted, %0d answers from fixed tracks",
               sb.n_new, sb.n_abort, sb.n_held);
      if (sb.errors == 0 && sb.verdicts.size() == 0) begin
         $display("track_label_stabilizer_core: match");
      end else begin
         $display("track_label_stabilizer_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/tls_pkg.sv
sv/tls_ram.sv
sv/tls_datapath.sv
sv/tls_ctrl.sv
sv/track_label_stabilizer_core.sv
verif/tb.sv
